>>> rtl/core/lpfr_pkg.sv
// Shared constants and types for the length-prefixed frame receiver.
package lpfr_pkg;

  localparam int unsigned BUFFER_DEPTH = 32768;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned ADDR_W  = 15;
  localparam int unsigned CAP_W   = 16;
  localparam int unsigned SUM_W   = 17;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Buffer depth as a value wide enough to hold any depth in its range.
  localparam logic [SUM_W-1:0] DEPTH_V = SUM_W'(BUFFER_DEPTH);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(32768);

  // Register indexes on the configuration port.
  localparam logic REG_BUFFER_CAPACITY = 1'b0;

  localparam logic REPLY_OK    = 1'b0;
  localparam logic REPLY_ERROR = 1'b1;

  localparam logic [1:0] PH_LEN_HIGH = 2'd0;
  localparam logic [1:0] PH_LEN_LOW  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD  = 2'd2;

  typedef struct packed {
    logic              store_enable;
    logic [ADDR_W-1:0] store_address;
    logic [BYTE_W-1:0] store_data;
    logic              reply_enable;
    logic              reply_code;
    logic              transfer_done;
    logic              transfer_failed;
    logic [LEN_W-1:0]  total_length;
  } result_t;

endpackage

>>> rtl/core/lpfr_cfg_regs.sv
// Configuration register block with the capacity clamp to the buffer depth.
module lpfr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpfr_pkg::PADDR_W-1:0]   paddr,
  input  logic [lpfr_pkg::PDATA_W-1:0]   pwdata,
  output logic [lpfr_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output logic [lpfr_pkg::SUM_W-1:0]     cap_eff
);
  import lpfr_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_BUFFER_CAPACITY);
  assign wr_en   = psel && penable && pwrite && pready && reg_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (wr_en) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) begin
      prdata = {{(PDATA_W-CAP_W){1'b0}}, capacity_r};
    end
  end

  // The usable capacity never exceeds what the buffer can hold.
  assign cap_eff = ({1'b0, capacity_r} > DEPTH_V) ? DEPTH_V : {1'b0, capacity_r};

endmodule

>>> rtl/core/length_prefixed_frame_receiver.sv
// Top level of the length-prefixed frame receiver: frame parser and result register.
//
//  channel   direction  handshake              contents
//  in_       input      in_valid / in_ready    rx_byte
//  out_      output     out_valid / out_ready  store, reply and transfer status
//  cfg       APB slave  psel/penable/pwrite    buffer_capacity at address 0
//
// One word is taken per cycle while in_ready is high; its result is registered in the output register.
// The parser state and the result register are updated at the same edge that accepts a word.
// A held result does not block input as long as the downstream side takes it in that cycle.
// Reset clears the parser state and the output valid; capacity returns to 32768.
module length_prefixed_frame_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lpfr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_store_enable,
  output logic [lpfr_pkg::ADDR_W-1:0]    out_store_address,
  output logic [lpfr_pkg::BYTE_W-1:0]    out_store_data,
  output logic                           out_reply_enable,
  output logic                           out_reply_code,
  output logic                           out_transfer_done,
  output logic                           out_transfer_failed,
  output logic [lpfr_pkg::LEN_W-1:0]     out_total_length,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lpfr_pkg::PADDR_W-1:0]   paddr,
  input  logic [lpfr_pkg::PDATA_W-1:0]   pwdata,
  output logic [lpfr_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import lpfr_pkg::*;

  logic [SUM_W-1:0]  cap_eff;
  logic              in_fire;

  logic [1:0]        phase_r,        phase_nxt;
  logic [BYTE_W-1:0] length_high_r,  length_high_nxt;
  logic [LEN_W-1:0]  remaining_r,    remaining_nxt;
  logic [LEN_W-1:0]  write_index_r,  write_index_nxt;
  logic              out_valid_r,    out_valid_nxt;
  result_t           result_r,       result_nxt;

  logic [LEN_W-1:0]  frame_len;
  logic [SUM_W-1:0]  frame_end;
  logic [LEN_W-1:0]  index_inc;
  logic [LEN_W-1:0]  remaining_dec;

  lpfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap_eff (cap_eff)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign frame_len     = {length_high_r, in_rx_byte};
  assign frame_end     = {1'b0, write_index_r} + {1'b0, frame_len};
  assign index_inc     = write_index_r + LEN_W'(1);
  assign remaining_dec = (remaining_r != '0) ? (remaining_r - LEN_W'(1)) : remaining_r;

  always_comb begin
    phase_nxt       = phase_r;
    length_high_nxt = length_high_r;
    remaining_nxt   = remaining_r;
    write_index_nxt = write_index_r;

    result_nxt                 = '0;
    result_nxt.reply_code      = REPLY_OK;
    result_nxt.total_length    = write_index_r;

    case (phase_r)
      PH_LEN_LOW: begin
        if (frame_len == '0) begin
          result_nxt.reply_enable  = 1'b1;
          result_nxt.transfer_done = 1'b1;
          phase_nxt       = PH_LEN_HIGH;
          write_index_nxt = '0;
          remaining_nxt   = '0;
        end else if (frame_end > cap_eff) begin
          result_nxt.reply_enable    = 1'b1;
          result_nxt.reply_code      = REPLY_ERROR;
          result_nxt.transfer_failed = 1'b1;
          result_nxt.total_length    = '0;
          phase_nxt       = PH_LEN_HIGH;
          write_index_nxt = '0;
          remaining_nxt   = '0;
        end else begin
          remaining_nxt = frame_len;
          phase_nxt     = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        result_nxt.store_enable  = 1'b1;
        result_nxt.store_address = write_index_r[ADDR_W-1:0];
        result_nxt.store_data    = in_rx_byte;
        result_nxt.total_length  = index_inc;
        write_index_nxt = index_inc;
        remaining_nxt   = remaining_dec;
        if (remaining_dec == '0) begin
          result_nxt.reply_enable = 1'b1;
          phase_nxt = PH_LEN_HIGH;
        end
      end
      default: begin
        // Waiting for the length high byte; the unused phase code behaves the same way.
        length_high_nxt = in_rx_byte;
        phase_nxt       = PH_LEN_LOW;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEN_HIGH;
      length_high_r <= '0;
      remaining_r   <= '0;
      write_index_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r       <= phase_nxt;
        length_high_r <= length_high_nxt;
        remaining_r   <= remaining_nxt;
        write_index_r <= write_index_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_store_enable    = result_r.store_enable;
  assign out_store_address   = result_r.store_address;
  assign out_store_data      = result_r.store_data;
  assign out_reply_enable    = result_r.reply_enable;
  assign out_reply_code      = result_r.reply_code;
  assign out_transfer_done   = result_r.transfer_done;
  assign out_transfer_failed = result_r.transfer_failed;
  assign out_total_length    = result_r.total_length;

  // A payload word always produces a store in the next result.
  a_payload_stores: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (phase_r == PH_PAYLOAD) |=> out_valid_r && result_r.store_enable)
    else $error("payload word did not produce a store");

  // A refused frame replies with an error and reports no stored length.
  a_fail_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && result_r.transfer_failed |->
      result_r.reply_enable && (result_r.reply_code == REPLY_ERROR) &&
      (result_r.total_length == '0) && !result_r.store_enable)
    else $error("failed transfer reported inconsistently");

  // Ending a transfer with a zero-length frame clears the write index and returns to the length high phase.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (phase_r == PH_LEN_LOW) && (frame_len == '0) |=>
      (write_index_r == '0) && (phase_r == PH_LEN_HIGH))
    else $error("write index not cleared at end of transfer");

  // The write index never runs past the buffer depth.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, write_index_r} <= DEPTH_V)
    else $error("write index beyond buffer depth");

endmodule
